### src/iacc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Igniter arm countdown controller package
// Shared types, register indices, status codes and reset values.
// ----------------------------------------------------------------------------
package iacc_pkg;

  // Number of targets wired to the select matrix (eight per row byte).
  localparam int unsigned TARGET_COUNT = 64;

  // Request types carried by an input word.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ARM    = 2'd1;
  localparam logic [1:0] REQ_IGNITE = 2'd2;

  // Status codes reported on every result word.
  localparam logic [1:0] ST_UNPOWERED = 2'd0;
  localparam logic [1:0] ST_UNARMED   = 2'd1;
  localparam logic [1:0] ST_ARMED     = 2'd2;
  localparam logic [1:0] ST_FIRING    = 2'd3;

  // Configuration register indices.
  localparam logic [1:0] CFG_FUSE_LENGTH       = 2'd0;
  localparam logic [1:0] CFG_TICK_INCREMENT    = 2'd1;
  localparam logic [1:0] CFG_POST_FIRE_HOLD    = 2'd2;
  localparam logic [1:0] CFG_BUTTON_HOLD_TICKS = 2'd3;

  // Register reset values.
  localparam logic [13:0] FUSE_LENGTH_RST       = 14'd7000;
  localparam logic [9:0]  TICK_INCREMENT_RST    = 10'd100;
  localparam logic [13:0] POST_FIRE_HOLD_RST    = 14'd5000;
  localparam logic [7:0]  BUTTON_HOLD_TICKS_RST = 8'd20;

  // Standby select word driven while armed.
  localparam logic [15:0] STANDBY_WORD = 16'h0101;

  // Request sequencer states.
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_PENDING = 3'b010,
    MODE_HOLD    = 3'b100
  } mode_t;

  typedef struct packed {
    logic [13:0] fuse_length;
    logic [9:0]  tick_increment;
    logic [13:0] post_fire_hold;
    logic [7:0]  button_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       arm_request;
    logic       use_next;
    logic [6:0] target_id;
    logic       power_ok;
    logic       button_down;
  } item_t;

  typedef struct packed {
    logic [1:0]         status_code;
    logic               is_armed;
    logic               fire_pulse;
    logic [6:0]         fired_target;
    logic [7:0]         row_byte;
    logic [7:0]         column_byte;
    logic               fire_line;
    logic signed [15:0] countdown_value;
  } result_t;

endpackage

### src/iacc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Igniter arm countdown controller channels
// Valid/ready interfaces for the request, result and configuration words.
// ----------------------------------------------------------------------------
interface iacc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       arm_request;
  logic       use_next;
  logic [6:0] target_id;
  logic       power_ok;
  logic       button_down;

  modport source (output valid, req_type, arm_request, use_next, target_id,
                  power_ok, button_down, input ready);
  modport sink   (input valid, req_type, arm_request, use_next, target_id,
                  power_ok, button_down, output ready);
endinterface

interface iacc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status_code;
  logic               is_armed;
  logic               fire_pulse;
  logic [6:0]         fired_target;
  logic [7:0]         row_byte;
  logic [7:0]         column_byte;
  logic               fire_line;
  logic signed [15:0] countdown_value;

  modport source (output valid, status_code, is_armed, fire_pulse, fired_target,
                  row_byte, column_byte, fire_line, countdown_value, input ready);
  modport sink   (input valid, status_code, is_armed, fire_pulse, fired_target,
                  row_byte, column_byte, fire_line, countdown_value, output ready);
endinterface

interface iacc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/iacc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Igniter arm countdown controller core
// Holds the controller state and works out one step per presented word.
// ----------------------------------------------------------------------------
module iacc_core #(
  parameter int unsigned TARGET_COUNT = iacc_pkg::TARGET_COUNT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  iacc_pkg::item_t   item,
  input  iacc_pkg::cfg_t    cfg,
  output iacc_pkg::result_t result
);
  import iacc_pkg::*;

  // State registers. The standby word and fire line follow the armed flag,
  // so they are derived from it rather than stored.
  logic               armed_r,      armed_nxt;
  logic               power_seen_r, power_seen_nxt;
  mode_t              mode_r,       mode_nxt;
  logic [6:0]         req_tgt_r,    req_tgt_nxt;
  logic [6:0]         next_tgt_r,   next_tgt_nxt;
  logic signed [15:0] cd_r,         cd_nxt;
  logic [7:0]         press_r,      press_nxt;
  logic [1:0]         status_r,     status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      power_seen_r <= 1'b0;
      mode_r       <= MODE_IDLE;
      req_tgt_r    <= '0;
      next_tgt_r   <= '0;
      cd_r         <= '0;
      press_r      <= '0;
      status_r     <= ST_UNPOWERED;
    end else if (step_en) begin
      armed_r      <= armed_nxt;
      power_seen_r <= power_seen_nxt;
      mode_r       <= mode_nxt;
      req_tgt_r    <= req_tgt_nxt;
      next_tgt_r   <= next_tgt_nxt;
      cd_r         <= cd_nxt;
      press_r      <= press_nxt;
      status_r     <= status_nxt;
    end
  end

  // Step logic: the request is applied in order, then the tick bookkeeping.
  logic signed [16:0] cd_v;
  logic signed [16:0] sum_v;
  logic               pulse_v;
  logic [6:0]         ptgt_v;
  logic [7:0]         row_v;
  logic [7:0]         col_v;
  logic               press_hit_v;

  always_comb begin
    armed_nxt      = armed_r;
    power_seen_nxt = power_seen_r;
    mode_nxt       = mode_r;
    req_tgt_nxt    = req_tgt_r;
    next_tgt_nxt   = next_tgt_r;
    press_nxt      = press_r;
    status_nxt     = status_r;
    cd_v           = 17'(cd_r);
    sum_v          = '0;
    pulse_v        = 1'b0;
    ptgt_v         = '0;
    row_v          = '0;
    col_v          = '0;
    press_hit_v    = 1'b0;

    case (item.req_type)
      REQ_ARM: begin
        // A matching state is ignored, and arming needs power.
        if ((item.arm_request != armed_r) && !(item.arm_request && !item.power_ok)) begin
          armed_nxt = item.arm_request;
          mode_nxt  = MODE_IDLE;
          cd_v      = '0;
        end
      end
      REQ_IGNITE: begin
        if (item.power_ok) begin
          cd_v        = -$signed({3'b000, cfg.fuse_length});
          mode_nxt    = MODE_PENDING;
          req_tgt_nxt = item.use_next ? next_tgt_r : item.target_id;
        end
      end
      REQ_TICK: begin
        // A change in power disarms.
        if (item.power_ok != power_seen_r) begin
          power_seen_nxt = item.power_ok;
          if (armed_r) begin
            armed_nxt = 1'b0;
            mode_nxt  = MODE_IDLE;
            cd_v      = '0;
          end
        end

        // Button hold counter, which ignites the next target once.
        if (item.button_down && (status_r == ST_ARMED)) begin
          if (press_r != 8'hFF) begin
            press_nxt = press_r + 8'd1;
          end
          press_hit_v = (press_r == cfg.button_hold_ticks);
          if (press_hit_v && item.power_ok) begin
            cd_v        = -$signed({3'b000, cfg.fuse_length});
            mode_nxt    = MODE_PENDING;
            req_tgt_nxt = next_tgt_r;
          end
        end else begin
          press_nxt = '0;
        end

        // Countdown advance, ignition and post-fire hold.
        if (item.power_ok) begin
          if (!armed_nxt) begin
            mode_nxt = MODE_IDLE;
          end else if (mode_nxt != MODE_IDLE) begin
            sum_v = cd_v + $signed({7'b0000000, cfg.tick_increment});
            cd_v  = sum_v;
            if ((mode_nxt == MODE_PENDING) && !sum_v[16]) begin
              pulse_v = 1'b1;
              ptgt_v  = req_tgt_nxt;
              if (32'(req_tgt_nxt) < TARGET_COUNT) begin
                row_v = 8'(1) << req_tgt_nxt[5:3];
              end
              col_v        = 8'(1) << req_tgt_nxt[2:0];
              next_tgt_nxt = (req_tgt_nxt != 7'h7F) ? req_tgt_nxt + 7'd1 : 7'h7F;
              mode_nxt     = MODE_HOLD;
            end else if (sum_v >= $signed({3'b000, cfg.post_fire_hold})) begin
              mode_nxt = MODE_IDLE;
              cd_v     = '0;
            end
          end
        end

        // Status is refreshed only at the end of a tick.
        if (!item.power_ok) begin
          status_nxt = ST_UNPOWERED;
        end else if (!armed_nxt) begin
          status_nxt = ST_UNARMED;
        end else if (mode_nxt == MODE_IDLE) begin
          status_nxt = ST_ARMED;
        end else begin
          status_nxt = ST_FIRING;
        end
      end
      default: begin
      end
    endcase

    cd_nxt = cd_v[15:0];

    result.status_code     = status_nxt;
    result.is_armed        = armed_nxt;
    result.fire_pulse      = pulse_v;
    result.fired_target    = ptgt_v;
    result.row_byte        = pulse_v ? row_v : (armed_nxt ? STANDBY_WORD[15:8] : 8'h00);
    result.column_byte     = pulse_v ? col_v : (armed_nxt ? STANDBY_WORD[7:0] : 8'h00);
    result.fire_line       = armed_nxt;
    result.countdown_value = cd_v[15:0];
  end

endmodule

### src/ignition_arm_countdown_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Igniter arm countdown controller
// Input register, one-step state update and result register.
// ----------------------------------------------------------------------------
// Each request word gives exactly one result word. A word is taken into an
// input register, and in the cycle it moves on the controller state is
// updated and the result is captured in the output register, so the block
// takes one word per clock while the result side keeps up; the throughput
// is set by the single state update per cycle. Configuration writes are
// always accepted and should be made while no word is in flight.
module ignition_arm_countdown_controller #(
  parameter int unsigned TARGET_COUNT = iacc_pkg::TARGET_COUNT
) (
  input logic       clk,
  input logic       rst_n,
  iacc_in_if.sink   in_ch,
  iacc_out_if.source out_ch,
  iacc_cfg_if.sink  cfg_ch
);
  import iacc_pkg::*;

  // Configuration registers.
  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fuse_length       <= FUSE_LENGTH_RST;
      cfg_r.tick_increment    <= TICK_INCREMENT_RST;
      cfg_r.post_fire_hold    <= POST_FIRE_HOLD_RST;
      cfg_r.button_hold_ticks <= BUTTON_HOLD_TICKS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_FUSE_LENGTH:       cfg_r.fuse_length       <= cfg_ch.data;
        CFG_TICK_INCREMENT:    cfg_r.tick_increment    <= cfg_ch.data[9:0];
        CFG_POST_FIRE_HOLD:    cfg_r.post_fire_hold    <= cfg_ch.data;
        CFG_BUTTON_HOLD_TICKS: cfg_r.button_hold_ticks <= cfg_ch.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input register stage.
  logic  in_valid_r;
  item_t in_item_r;
  logic  out_valid_r;
  logic  step;

  assign step         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.req_type    <= in_ch.req_type;
      in_item_r.arm_request <= in_ch.arm_request;
      in_item_r.use_next    <= in_ch.use_next;
      in_item_r.target_id   <= in_ch.target_id;
      in_item_r.power_ok    <= in_ch.power_ok;
      in_item_r.button_down <= in_ch.button_down;
    end
  end

  // Controller state and step logic.
  result_t step_res;

  iacc_core #(
    .TARGET_COUNT (TARGET_COUNT)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .result  (step_res)
  );

  // Result register stage.
  result_t out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status_code     = out_res_r.status_code;
  assign out_ch.is_armed        = out_res_r.is_armed;
  assign out_ch.fire_pulse      = out_res_r.fire_pulse;
  assign out_ch.fired_target    = out_res_r.fired_target;
  assign out_ch.row_byte        = out_res_r.row_byte;
  assign out_ch.column_byte     = out_res_r.column_byte;
  assign out_ch.fire_line       = out_res_r.fire_line;
  assign out_ch.countdown_value = out_res_r.countdown_value;

endmodule
